@@ rtl/rrts_pkg.sv @@
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants of the round-robin task scheduler: request
// kinds, controller command and status bundles, fixed field widths.
// ----------------------------------------------------------------------------
package rrts_pkg;

  // fixed widths of the request and result fields
  localparam int ID_W     = 4;
  localparam int MAX_IDS  = 16;
  localparam int MS_W     = 32;
  localparam int CNT_W    = 5;
  localparam int SLICE_W  = 8;

  // time slice after reset
  localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd10;

  // request kinds
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_YIELD = 2'd2,
    KIND_SLEEP = 2'd3
  } kind_t;

  // configuration register indexes
  localparam int REG_TIME_SLICE = 0;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic start;
    logic tick;
    logic sweep_upd;
    logic yield;
    logic sleep_commit;
    logic finish;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic slen_zero;
    logic sweep_last;
    logic idle_act;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/rrts_ctrl.sv @@
// ----------------------------------------------------------------------------
// rrts_ctrl
// Sequencer of the scheduler: takes a request, walks the datapath through
// the steps its kind needs (task start, slice update, sleeper sweep, yield,
// sleep commit and dispatch), then hands off the result.
// ----------------------------------------------------------------------------
module rrts_ctrl
  import rrts_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  kind_t kind,
  input  stat_t stat,
  output logic  in_ready,
  output cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_START = 10'b00_0000_0010,
    S_TICK  = 10'b00_0000_0100,
    S_ORD   = 10'b00_0000_1000,
    S_LEFT  = 10'b00_0001_0000,
    S_UPD   = 10'b00_0010_0000,
    S_YIELD = 10'b00_0100_0000,
    S_SLEEP = 10'b00_1000_0000,
    S_DISP  = 10'b01_0000_0000,
    S_FIN   = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (kind)
            KIND_TICK:  state_next = S_TICK;
            KIND_START: state_next = S_START;
            KIND_YIELD: state_next = S_YIELD;
            KIND_SLEEP: state_next = stat.idle_act ? S_DISP : S_SLEEP;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_START: begin
        cmd.start  = 1'b1;
        state_next = S_FIN;
      end
      S_TICK: begin
        cmd.tick   = 1'b1;
        state_next = stat.slen_zero ? S_DISP : S_ORD;
      end
      S_ORD:  state_next = S_LEFT;
      S_LEFT: state_next = S_UPD;
      S_UPD: begin
        cmd.sweep_upd = 1'b1;
        state_next    = stat.sweep_last ? S_DISP : S_ORD;
      end
      S_YIELD: begin
        cmd.yield  = 1'b1;
        state_next = S_DISP;
      end
      S_SLEEP: begin
        cmd.sleep_commit = 1'b1;
        state_next       = S_DISP;
      end
      S_DISP: state_next = S_FIN;
      S_FIN: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/rrts_datapath.sv @@
// ----------------------------------------------------------------------------
// rrts_datapath
// Ready queue and sleep list as circular buffers, per-task sleep counters,
// slice counters, membership bitmaps and result register.
// ----------------------------------------------------------------------------
module rrts_datapath
  import rrts_pkg::*;
#(
  parameter int NUM_TASKS = 16,
  parameter int TICK_MS   = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic [SLICE_W-1:0] time_slice,
  input  kind_t              kind,
  input  logic [ID_W-1:0]    task_id,
  input  logic [MS_W-1:0]    sleep_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ID_W-1:0]    running_task,
  output logic               idle_running,
  output logic               switched,
  output logic [CNT_W-1:0]   ready_count,
  output logic               rejected
);

  // ids never exceed 16 distinct values, so queues need no more slots
  localparam int Q   = (NUM_TASKS < MAX_IDS) ? NUM_TASKS : MAX_IDS;
  localparam int IW  = $clog2(Q);
  localparam int LW  = $clog2(Q + 1);

  function automatic logic [IW-1:0] inc(input logic [IW-1:0] p);
    inc = (p == IW'(Q - 1)) ? '0 : p + 1'b1;
  endfunction

  // request and control state
  kind_t              kind_q;
  logic [ID_W-1:0]    tid_q;
  logic [MS_W-1:0]    sleep_q;
  logic               rej;
  logic [IW-1:0]      cur;
  logic               idle_act;
  logic [IW-1:0]      rhead, rtail, shead, stail;
  logic [LW-1:0]      rlen, slen, rem;
  logic [Q-1:0]       in_rdy, in_slp;
  logic [SLICE_W-1:0] slice [Q+1];

  // memories; a sleep counter holds the milliseconds left, always above zero
  logic [IW-1:0]   rmem [Q];
  logic [IW-1:0]   smem [Q];
  logic [MS_W-1:0] lmem [Q];
  logic [IW-1:0]   rmem_q, sord_q;
  logic [MS_W-1:0] left_q;

  // combinational helpers
  logic [IW-1:0]      tid_i;
  logic               tid_ok;
  logic [SLICE_W-1:0] load;
  logic [LW-1:0]      who;
  logic [SLICE_W-1:0] slice_cur;
  logic               expire, rotate_now, wake, has_room;
  logic               push_new, rwe, swe, lwe;
  logic [IW-1:0]      rwdata, swdata, lwaddr;
  logic [MS_W-1:0]    lwdata;
  logic               disp, new_idle, new_sw;
  logic [IW-1:0]      new_cur;

  assign tid_i     = tid_q[IW-1:0];
  assign tid_ok    = (int'(tid_q) < NUM_TASKS) && !in_rdy[tid_i] && !in_slp[tid_i];
  assign load      = (time_slice == '0) ? SLICE_W'(1) : time_slice;
  assign who       = idle_act ? LW'(Q) : LW'(cur);
  assign slice_cur = slice[who];
  assign expire    = slice_cur <= SLICE_W'(1);
  // one tick or less left, i.e. the rounded-up tick count is at most one
  assign wake      = left_q <= MS_W'(TICK_MS);
  assign has_room  = rlen < LW'(Q);

  // running task goes to the tail on slice expiry, or on yield while others are ready
  assign rotate_now = !idle_act &&
                      ((cmd.tick && expire) || (cmd.yield && rlen > LW'(1)));
  assign push_new   = ((cmd.start && tid_ok) || (cmd.sweep_upd && wake)) && has_room;

  // ready queue write port, always at the tail
  assign rwe    = rotate_now || push_new;
  assign rwdata = rotate_now ? cur : (cmd.start ? tid_i : sord_q);

  // sleep list and sleep counter write ports
  assign swe    = (cmd.sweep_upd && !wake) || cmd.sleep_commit;
  assign swdata = cmd.sleep_commit ? cur : sord_q;
  assign lwe    = swe;
  assign lwaddr = cmd.sleep_commit ? cur : sord_q;
  assign lwdata = cmd.sleep_commit ? sleep_q : left_q - MS_W'(TICK_MS);

  // dispatch result
  assign disp     = (kind_q != KIND_START);
  assign new_idle = disp ? (rlen == '0) : idle_act;
  assign new_cur  = (disp && rlen != '0) ? rmem_q : cur;
  assign new_sw   = (new_idle != idle_act) || (!new_idle && new_cur != cur);

  // memories, registered read
  always_ff @(posedge clk) begin
    if (rwe) begin
      rmem[rtail] <= rwdata;
    end
    if (swe) begin
      smem[stail] <= swdata;
    end
    if (lwe) begin
      lmem[lwaddr] <= lwdata;
    end
    rmem_q <= rmem[rhead];
    sord_q <= smem[shead];
    left_q <= lmem[sord_q];
  end

  // request payload; short sleeps are raised to one tick
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_q  <= kind;
      tid_q   <= task_id;
      sleep_q <= (sleep_ms < MS_W'(TICK_MS)) ? MS_W'(TICK_MS) : sleep_ms;
    end
  end

  // scheduler state
  always_ff @(posedge clk) begin
    if (rst) begin
      rej       <= 1'b0;
      cur       <= '0;
      idle_act  <= 1'b1;
      rhead     <= '0;
      rtail     <= '0;
      rlen      <= '0;
      shead     <= '0;
      stail     <= '0;
      slen      <= '0;
      rem       <= '0;
      in_rdy    <= '0;
      in_slp    <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i <= Q; i++) begin
        slice[i] <= SLICE_RESET;
      end
    end else begin
      if (cmd.accept) begin
        rej <= (kind == KIND_SLEEP) && idle_act;
      end

      // ready queue pointers
      if (rwe) begin
        rtail <= inc(rtail);
      end
      if (rotate_now || cmd.sleep_commit) begin
        rhead <= inc(rhead);
      end
      if (push_new) begin
        rlen <= rlen + 1'b1;
      end else if (cmd.sleep_commit) begin
        rlen <= rlen - 1'b1;
      end

      // start
      if (cmd.start) begin
        if (tid_ok) begin
          slice[tid_i] <= load;
          if (has_room) begin
            in_rdy[tid_i] <= 1'b1;
          end
        end else begin
          rej <= 1'b1;
        end
      end

      // slice accounting on a tick
      if (cmd.tick) begin
        slice[who] <= expire ? load : slice_cur - 1'b1;
        rem        <= slen;
      end

      // one sleeper per pass
      if (cmd.sweep_upd) begin
        shead <= inc(shead);
        rem   <= rem - 1'b1;
        if (wake) begin
          slen           <= slen - 1'b1;
          in_slp[sord_q] <= 1'b0;
          if (has_room) begin
            in_rdy[sord_q] <= 1'b1;
          end
        end else begin
          stail <= inc(stail);
        end
      end

      // running task goes to sleep
      if (cmd.sleep_commit) begin
        stail       <= inc(stail);
        slen        <= slen + 1'b1;
        in_rdy[cur] <= 1'b0;
        in_slp[cur] <= 1'b1;
      end

      // dispatch and result
      if (cmd.finish) begin
        idle_act     <= new_idle;
        cur          <= new_cur;
        out_valid    <= 1'b1;
        running_task <= new_idle ? '0 : ID_W'(new_cur);
        idle_running <= new_idle;
        switched     <= new_sw;
        ready_count  <= CNT_W'(rlen);
        rejected     <= rej;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.slen_zero  = (slen == '0);
  assign stat.sweep_last = (rem == LW'(1));
  assign stat.idle_act   = idle_act;
  assign stat.out_free   = !out_valid || out_ready;

  // a task is never both ready and asleep
  a_disjoint: assert property (@(posedge clk) disable iff (rst)
    (in_rdy & in_slp) == '0)
    else $error("task both ready and sleeping");

  // bitmaps track the queue lengths
  a_rlen: assert property (@(posedge clk) disable iff (rst)
    $countones(in_rdy) == int'(rlen))
    else $error("ready bitmap out of step with queue length");

  a_slen: assert property (@(posedge clk) disable iff (rst)
    $countones(in_slp) == int'(slen))
    else $error("sleep bitmap out of step with list length");

  // a dispatch onto a non-empty queue leaves a real task running
  a_disp: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && disp && rlen != '0) |=> !idle_act)
    else $error("idle selected with tasks ready");

endmodule

@@ rtl/round_robin_task_scheduler.sv @@
// ----------------------------------------------------------------------------
// round_robin_task_scheduler
// Round-robin task scheduler with time slices and timed sleep.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready with kind, task_id and sleep_ms:
//   tick, start task, yield, sleep running task. Each request gives exactly
//   one result on out_valid/out_ready: running task, idle flag, switch flag,
//   ready queue length and reject flag.
//   time_slice sits at APB address 0. The user must write it only while no
//   request is in flight; the block itself does not enforce this.
//   A sleep request while idle runs is rejected and skips the sleep commit.
//   A tick visits each sleeper in turn (list read, counter read, update).
//   Sleep counters keep milliseconds, start at no less than TICK_MS, and
//   drop by TICK_MS per tick, so no division is needed.
//   One request is worked at a time. The result register frees the input:
//   a new request is taken while a result still waits, and a finished
//   request waits only when the previous result has not been taken.
//   Reset empties both queues, makes idle run and loads every slice
//   counter and time_slice with 10. No clearing pass is needed.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler
  import rrts_pkg::*;
#(
  parameter int NUM_TASKS = 16,
  parameter int TICK_MS   = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [1:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       kind,
  input  logic [ID_W-1:0]  task_id,
  input  logic [MS_W-1:0]  sleep_ms,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ID_W-1:0]  running_task,
  output logic             idle_running,
  output logic             switched,
  output logic [CNT_W-1:0] ready_count,
  output logic             rejected
);

  logic [SLICE_W-1:0] time_slice;
  logic [1:0]         reg_idx;
  cmd_t               cmd;
  stat_t              stat;
  kind_t              kind_in;

  assign kind_in = kind_t'(kind);
  assign reg_idx = paddr >> 2;

  // configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_slice <= SLICE_RESET;
    end else if (psel && penable && pwrite && int'(reg_idx) == REG_TIME_SLICE) begin
      time_slice <= pwdata[SLICE_W-1:0];
    end
  end

  assign prdata = (int'(reg_idx) == REG_TIME_SLICE) ? 32'(time_slice) : '0;

  rrts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind_in),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  rrts_datapath #(
    .NUM_TASKS (NUM_TASKS),
    .TICK_MS   (TICK_MS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .time_slice   (time_slice),
    .kind         (kind_in),
    .task_id      (task_id),
    .sleep_ms     (sleep_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .running_task (running_task),
    .idle_running (idle_running),
    .switched     (switched),
    .ready_count  (ready_count),
    .rejected     (rejected)
  );

endmodule
